### src/slxfp_pkg.sv
package slxfp_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_LEN,
      ST_SUM,
      ST_SCAN_RD,
      ST_SCAN,
      ST_OUT_ADDR,
      ST_OUT_DATA
   } state_type;

   localparam logic [7:0] START_RESET  = 8'hFE;
   localparam logic [7:0] TYPE_MASK    = 8'hE0;
   localparam logic [7:0] SUBSYS_MASK  = 8'h1F;
   localparam int         TYPE_SHIFT   = 5;
   // length byte plus framing overhead
   localparam int         TOT_W        = 9;
   localparam logic [8:0] FRAME_EXTRA  = 9'd5;

endpackage

### src/slxfp_ram.sv
module slxfp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/sof_length_xor_frame_parser.sv
// Serial frame parser: start byte, length L, cmd0, cmd1, L payload bytes, check.
// req channel: one received byte per request (req_rx_byte). rsp channel: one
// result per payload byte of a good frame (one result for an empty payload),
// the final one flagged by rsp_last. csr channel: writes the start byte value,
// always ready; write it only while the parser is idle.
// Sequence: a byte taken while hunting is dropped or stored as the start byte.
// Any other byte is stored, then the length is fetched (EVAL, LEN); a short
// candidate waits for more bytes, else the checksum pass runs (SUM), each
// result is read and loaded (OUT_ADDR, OUT_DATA) and the buffer is scanned
// to realign on the next start byte (SCAN_RD, SCAN). A check failure or an
// oversized length rescans the buffer the same way before the next byte is
// taken; every buffered start byte may begin another checksum pass. The pace
// is set by the single read port of the byte buffer, read once per cycle by
// one sequencer.
// Reset (synchronous, active high) empties the buffer, restores the start
// byte to 0xFE and drops any pending result.
// A stalled rsp receiver holds the result register; the parser waits for it
// before loading the next result, and req_ready stays low meanwhile.
module sof_length_xor_frame_parser #(
   parameter int MAX_PAYLOAD = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_frame_type,
   output logic [4:0] rsp_subsystem,
   output logic [7:0] rsp_command,
   output logic [6:0] rsp_payload_len,
   output logic [7:0] rsp_payload_byte,
   output logic [5:0] rsp_byte_index,
   output logic       rsp_last,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_start_byte
);

   import slxfp_pkg::*;

   localparam int BUF_DEPTH  = MAX_PAYLOAD + 5;
   localparam int FILL_W     = $clog2(BUF_DEPTH + 1);
   localparam int ADDR_W     = $clog2(BUF_DEPTH);
   localparam int RING_DEPTH = 1 << ADDR_W;

   state_type state_ff, state_in;

   logic [7:0]        start_ff, start_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [ADDR_W-1:0] head_ff, head_in;
   logic [FILL_W-1:0] j_ff, j_in;
   logic [FILL_W-1:0] k_ff, k_in;
   logic [7:0]        len_ff, len_in;
   logic [7:0]        chk_ff, chk_in;
   logic [7:0]        c0_ff, c0_in;
   logic [7:0]        c1_ff, c1_in;
   logic [7:0]        idx_ff, idx_in;
   logic              after_ff, after_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [2:0]        rsp_type_ff, rsp_type_in;
   logic [4:0]        rsp_subsys_ff, rsp_subsys_in;
   logic [7:0]        rsp_cmd_ff, rsp_cmd_in;
   logic [6:0]        rsp_len_ff, rsp_len_in;
   logic [7:0]        rsp_byte_ff, rsp_byte_in;
   logic [5:0]        rsp_index_ff, rsp_index_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr;
   logic [7:0]        rd_data;

   logic              req_fire;
   logic              len_too_big;
   logic              len_short;
   logic              sum_done;
   logic              chk_ok;
   logic              scan_end;
   logic              scan_hit;
   logic              scan_last;
   logic              out_free;
   logic              out_last;
   logic [7:0]        type_bits;
   logic [7:0]        subsys_bits;
   logic [FILL_W-1:0] frame_total;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign len_too_big = TOT_W'(rd_data) > TOT_W'(MAX_PAYLOAD);
   assign len_short   = TOT_W'(fill_ff) < (TOT_W'(rd_data) + FRAME_EXTRA);
   assign sum_done    = (k_ff == FILL_W'(len_ff) + FILL_W'(4));
   assign chk_ok      = (chk_ff == rd_data);
   assign scan_end    = (j_ff >= fill_ff);
   assign scan_hit    = (rd_data == start_ff);
   assign scan_last   = (j_ff + FILL_W'(1) >= fill_ff);
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign out_last    = (len_ff == 8'd0) || (idx_ff == len_ff - 8'd1);
   assign frame_total = FILL_W'(len_ff) + FILL_W'(5);
   assign type_bits   = (c0_ff & TYPE_MASK) >> TYPE_SHIFT;
   assign subsys_bits = c0_ff & SUBSYS_MASK;

   // byte buffer, kept as a ring: head_ff is the candidate start byte
   slxfp_ram #(
      .WIDTH (8),
      .DEPTH (RING_DEPTH)
   ) u_buf (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_rx_byte),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && fill_ff != '0) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            state_in = (fill_ff < FILL_W'(2)) ? ST_IDLE : ST_LEN;
         end
         ST_LEN: begin
            if (len_too_big) begin
               state_in = ST_SCAN_RD;
            end else if (len_short) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            if (sum_done) begin
               state_in = chk_ok ? ST_OUT_ADDR : ST_SCAN_RD;
            end
         end
         ST_SCAN_RD: begin
            if (scan_end) begin
               state_in = after_ff ? ST_IDLE : ST_EVAL;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_hit || scan_last) begin
               state_in = after_ff ? ST_IDLE : ST_EVAL;
            end
         end
         ST_OUT_ADDR: begin
            if (out_free) begin
               state_in = ST_OUT_DATA;
            end
         end
         ST_OUT_DATA: begin
            state_in = out_last ? ST_SCAN_RD : ST_OUT_ADDR;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // buffer port control and datapath
   always_comb begin
      wr_en         = 1'b0;
      wr_addr       = head_ff + ADDR_W'(fill_ff);
      rd_addr       = head_ff;
      start_in      = start_ff;
      fill_in       = fill_ff;
      head_in       = head_ff;
      j_in          = j_ff;
      k_in          = k_ff;
      len_in        = len_ff;
      chk_in        = chk_ff;
      c0_in         = c0_ff;
      c1_in         = c1_ff;
      idx_in        = idx_ff;
      after_in      = after_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_type_in   = rsp_type_ff;
      rsp_subsys_in = rsp_subsys_ff;
      rsp_cmd_in    = rsp_cmd_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_last_in   = rsp_last_ff;

      if (csr_valid && csr_ready) begin
         start_in = csr_start_byte;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (fill_ff == '0) begin
                  if (req_rx_byte == start_ff) begin
                     wr_en   = 1'b1;
                     wr_addr = head_ff;
                     fill_in = FILL_W'(1);
                  end
               end else if (fill_ff < FILL_W'(BUF_DEPTH)) begin
                  wr_en   = 1'b1;
                  fill_in = fill_ff + FILL_W'(1);
               end
            end
         end
         ST_EVAL: begin
            rd_addr = head_ff + ADDR_W'(1);
         end
         ST_LEN: begin
            // checksum reads run one address ahead of the data
            rd_addr = head_ff + ADDR_W'(2);
            len_in  = rd_data;
            chk_in  = rd_data;
            k_in    = FILL_W'(2);
            if (len_too_big) begin
               j_in     = FILL_W'(1);
               after_in = 1'b0;
            end
         end
         ST_SUM: begin
            rd_addr = head_ff + ADDR_W'(k_ff) + ADDR_W'(1);
            if (k_ff == FILL_W'(2)) begin
               c0_in = rd_data;
            end
            if (k_ff == FILL_W'(3)) begin
               c1_in = rd_data;
            end
            if (!sum_done) begin
               chk_in = chk_ff ^ rd_data;
               k_in   = k_ff + FILL_W'(1);
            end else if (chk_ok) begin
               idx_in = 8'd0;
            end else begin
               j_in     = FILL_W'(1);
               after_in = 1'b0;
            end
         end
         ST_SCAN_RD: begin
            rd_addr = head_ff + ADDR_W'(j_ff);
            if (scan_end) begin
               fill_in = '0;
            end
         end
         ST_SCAN: begin
            rd_addr = head_ff + ADDR_W'(j_ff) + ADDR_W'(1);
            if (scan_hit) begin
               head_in = head_ff + ADDR_W'(j_ff);
               fill_in = fill_ff - j_ff;
            end else if (scan_last) begin
               fill_in = '0;
            end else begin
               j_in = j_ff + FILL_W'(1);
            end
         end
         ST_OUT_ADDR: begin
            rd_addr = head_ff + ADDR_W'(4) + ADDR_W'(idx_ff);
         end
         ST_OUT_DATA: begin
            // result register is free here: OUT_ADDR waited for it
            rsp_valid_in  = 1'b1;
            rsp_type_in   = type_bits[2:0];
            rsp_subsys_in = subsys_bits[4:0];
            rsp_cmd_in    = c1_ff;
            rsp_len_in    = len_ff[6:0];
            rsp_byte_in   = (len_ff == 8'd0) ? 8'd0 : rd_data;
            rsp_index_in  = (len_ff == 8'd0) ? 6'd0 : idx_ff[5:0];
            rsp_last_in   = out_last;
            if (out_last) begin
               j_in     = frame_total;
               after_in = 1'b1;
            end else begin
               idx_in = idx_ff + 8'd1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         start_ff     <= START_RESET;
         fill_ff      <= '0;
         head_ff      <= '0;
         after_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         fill_ff      <= fill_in;
         head_ff      <= head_in;
         after_ff     <= after_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      j_ff          <= j_in;
      k_ff          <= k_in;
      len_ff        <= len_in;
      chk_ff        <= chk_in;
      c0_ff         <= c0_in;
      c1_ff         <= c1_in;
      idx_ff        <= idx_in;
      rsp_type_ff   <= rsp_type_in;
      rsp_subsys_ff <= rsp_subsys_in;
      rsp_cmd_ff    <= rsp_cmd_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_frame_type   = rsp_type_ff;
   assign rsp_subsystem    = rsp_subsys_ff;
   assign rsp_command      = rsp_cmd_ff;
   assign rsp_payload_len  = rsp_len_ff;
   assign rsp_payload_byte = rsp_byte_ff;
   assign rsp_byte_index   = rsp_index_ff;
   assign rsp_last         = rsp_last_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(BUF_DEPTH))
      else $error("buffer fill count beyond depth");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_OUT_DATA |-> !rsp_valid_ff)
      else $error("result register overwritten while pending");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT_DATA))
      else $error("result raised outside the emit step");

   a_hunt_drop: assert property (@(posedge clock) disable iff (reset)
      req_fire && fill_ff == '0 && req_rx_byte != start_ff |=> fill_ff == '0)
      else $error("non-start byte stored while hunting");

   a_sum_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SUM |-> k_ff <= FILL_W'(len_ff) + FILL_W'(4))
      else $error("checksum counter ran past the frame");

endmodule
